### hdl/gpioei_pkg.sv
package gpioei_pkg;

  localparam int unsigned PortWidth = 16;

  // operation codes carried in the low bits of the input word
  typedef enum logic [2:0] {
    OP_SAMPLE    = 3'd0,
    OP_SET       = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_TOGGLE    = 3'd3,
    OP_WRITE_OUT = 3'd4,
    OP_WRITE_IRQ = 3'd5,
    OP_CLEAR_PND = 3'd6
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PIN_MODE   = 2'd0,
    CFG_OPEN_DRAIN = 2'd1,
    CFG_RISE_EN    = 2'd2,
    CFG_FALL_EN    = 2'd3
  } cfg_idx_e;

  // two-bit pin mode codes
  localparam logic [1:0] ModeOutput = 2'h1;
  localparam logic [1:0] ModeAnalog = 2'h3;

  typedef logic [PortWidth-1:0] port_t;

  // bit set for each pin whose mode field equals the code
  function automatic port_t pins_in_mode(logic [2*PortWidth-1:0] modes, logic [1:0] code);
    port_t r;
    r = '0;
    for (int i = 0; i < PortWidth; i++) begin
      r[i] = (modes[2*i +: 2] == code);
    end
    return r;
  endfunction

endpackage

### hdl/gpio_port_with_edge_interrupts.sv
// all work is per-bit logic; each word's result is written to a two-entry result buffer
// throughput: one word per cycle while s_axis_tready is high; m_axis reads the buffer
// the buffer lets a word be taken while one result still waits downstream
// s_axis_tready drops only when both result entries are occupied
// reset (rst_ni low, asynchronous) clears config, latches, pending bits, mask and buffer
module gpio_port_with_edge_interrupts #(
  parameter int unsigned NUM_PINS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // operation[2:0], pin_mask[18:3], pin_levels[34:19]
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // input_data, output_data, drive_enable,
                                      // pending_lines, irq (bit 64)
);
  import gpioei_pkg::*;

  // only the first sixteen pins exist on the 16-bit fields
  localparam int unsigned ActivePins = (NUM_PINS < PortWidth) ? NUM_PINS : PortWidth;
  localparam port_t PortMask = (ActivePins >= PortWidth) ? {PortWidth{1'b1}} :
                               PortWidth'((64'd1 << ActivePins) - 64'd1);

  // configuration registers
  logic [31:0] pin_mode_q;
  port_t       open_drain_q, rise_en_q, fall_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_mode_q   <= '0;
      open_drain_q <= '0;
      rise_en_q    <= '0;
      fall_en_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PIN_MODE:   pin_mode_q   <= cfg_data_i;
        CFG_OPEN_DRAIN: open_drain_q <= cfg_data_i[15:0];
        CFG_RISE_EN:    rise_en_q    <= cfg_data_i[15:0];
        CFG_FALL_EN:    fall_en_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // input word fields
  logic [2:0] op;
  port_t      arg, levels;
  assign op     = s_axis_tdata[2:0];
  assign arg    = s_axis_tdata[18:3] & PortMask;
  assign levels = s_axis_tdata[34:19] & PortMask;

  logic s_acc, m_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  // port state
  port_t input_q, input_d;
  port_t output_q, output_d;
  port_t pending_q, pending_d;
  port_t mask_q, mask_d;

  port_t analog_pins, output_pins, now, rise, fall, drive;

  assign analog_pins = pins_in_mode(pin_mode_q, ModeAnalog) & PortMask;
  assign output_pins = pins_in_mode(pin_mode_q, ModeOutput) & PortMask;

  // analog pins read as low and so never produce rising edges
  assign now  = levels & ~analog_pins;
  assign rise = now & ~input_q & rise_en_q;
  assign fall = ~now & input_q & fall_en_q;

  always_comb begin
    input_d   = input_q;
    output_d  = output_q;
    pending_d = pending_q;
    mask_d    = mask_q;
    case (op)
      OP_SAMPLE: begin
        pending_d = (pending_q | rise | fall) & PortMask;
        input_d   = now;
      end
      OP_SET:       output_d  = output_q | arg;
      OP_CLEAR:     output_d  = output_q & ~arg;
      OP_TOGGLE:    output_d  = output_q ^ arg;
      OP_WRITE_OUT: output_d  = arg;
      OP_WRITE_IRQ: mask_d    = arg;
      OP_CLEAR_PND: pending_d = pending_q & ~arg;
      default: ;    // unknown operation leaves the state alone
    endcase
  end

  // open-drain pins drive only while their latch bit is low
  assign drive = output_pins & (~open_drain_q | ~output_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_q   <= '0;
      output_q  <= '0;
      pending_q <= '0;
      mask_q    <= '0;
    end else if (s_acc) begin
      input_q   <= input_d;
      output_q  <= output_d;
      pending_q <= pending_d;
      mask_q    <= mask_d;
    end
  end

  // result word, taken from the state after this word
  logic [71:0] result;
  assign result = {7'd0, |(pending_d & mask_d), pending_d, drive, output_d, input_d};

  // two-entry result buffer
  logic [71:0] buf_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      buf_q[wr_ptr_q] <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (s_acc) wr_ptr_q <= ~wr_ptr_q;
      if (m_acc) rd_ptr_q <= ~rd_ptr_q;
      case ({s_acc, m_acc})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign s_axis_tready = (count_q != 2'd2);
  assign m_axis_tvalid = (count_q != 2'd0);
  assign m_axis_tdata  = buf_q[rd_ptr_q];

  // buffer occupancy stays within its two entries
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer count out of range");

  // pending bits never set on pins that do not exist
  a_pending_in_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q & ~PortMask) == '0)
    else $error("pending bit set beyond port width");

  // pending bits only grow on a sample tick
  a_pending_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_acc && (op == OP_SAMPLE)) |=> ((pending_q & ~$past(pending_q)) == '0))
    else $error("pending bit set without a sample");

  // output latch and interrupt mask hold while no word is taken
  a_latch_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_acc |=> $stable(output_q) && $stable(mask_q))
    else $error("latch changed without an input word");

endmodule
